### rtl/sm4_pkg.sv
// Package for the SM4 block cipher unit: item types, state machine codes,
// register indexes, the S-box table and the round function helpers.
// No dependencies.
`timescale 1ns / 1ps
package sm4_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } block_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_LOAD,
    ST_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_key;
    logic load_blk;
    logic step;
    logic key_sched;
  } dp_ctrl_t;

  localparam int ROUNDS = 32;
  localparam int RK_AW  = 5;

  localparam logic [1:0] REG_KEY_HIGH     = 2'd0;
  localparam logic [1:0] REG_KEY_LOW      = 2'd1;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

  localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] lin_data(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] lin_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // byte j of CK[i] is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
    logic [7:0]  base;
    logic [31:0] w;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return w;
  endfunction

endpackage

### rtl/sm4_key_ram.sv
// Round key store: 32 x 32-bit synchronous memory, one write and one read port.
// Read data is registered. Uses sm4_pkg.
`timescale 1ns / 1ps
module sm4_key_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [sm4_pkg::RK_AW-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [sm4_pkg::RK_AW-1:0] raddr,
  output logic [31:0]              rdata
);
  import sm4_pkg::*;

  logic [31:0] mem [ROUNDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sm4_datapath.sv
// Shared round unit: four-word window plus one S-box round per cycle while step
// is high, used for both key expansion and data rounds. Uses sm4_pkg.
`timescale 1ns / 1ps
module sm4_datapath (
  input  logic                      clk,
  input  sm4_pkg::dp_ctrl_t         ctrl,
  input  logic [sm4_pkg::RK_AW-1:0] cnt,
  input  logic [127:0]              key,
  input  logic [127:0]              blk,
  input  logic [31:0]               rk,
  output logic [31:0]               new_word,
  output sm4_pkg::result_t          result
);
  import sm4_pkg::*;

  logic [31:0] w [4];
  logic [31:0] mix;
  logic [31:0] sb;
  logic [127:0] kx;

  assign kx = key ^ FK;

  always_comb begin
    mix      = w[1] ^ w[2] ^ w[3] ^ (ctrl.key_sched ? ck_word(cnt) : rk);
    sb       = sub_word(mix);
    new_word = w[0] ^ (ctrl.key_sched ? lin_key(sb) : lin_data(sb));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_key) begin
      w[0] <= kx[127:96];
      w[1] <= kx[95:64];
      w[2] <= kx[63:32];
      w[3] <= kx[31:0];
    end else if (ctrl.load_blk) begin
      w[0] <= blk[127:96];
      w[1] <= blk[95:64];
      w[2] <= blk[63:32];
      w[3] <= blk[31:0];
    end else if (ctrl.step) begin
      w[0] <= w[1];
      w[1] <= w[2];
      w[2] <= w[3];
      w[3] <= new_word;
    end
  end

  assign result.result_high = {w[3], w[2]};
  assign result.result_low  = {w[1], w[0]};

endmodule

### rtl/sm4_ctrl.sv
// Sequencer: runs key expansion when the key changed, then the 32 data rounds,
// and drives the round key store addresses. Uses sm4_pkg.
`timescale 1ns / 1ps
module sm4_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      key_write,
  input  logic                      decrypt_mode,
  output logic                      busy,
  output logic                      done,
  output sm4_pkg::dp_ctrl_t         ctrl,
  output logic [sm4_pkg::RK_AW-1:0] cnt,
  output logic                      ram_we,
  output logic [sm4_pkg::RK_AW-1:0] ram_raddr
);
  import sm4_pkg::*;

  state_t             state;
  state_t             state_next;
  logic               keys_ready;
  logic [RK_AW-1:0]   ridx;
  logic               last;

  assign last = (cnt == RK_AW'(ROUNDS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = keys_ready ? ST_LOAD : ST_KEY;
        end
      end
      ST_KEY:  if (last) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DATA;
      ST_DATA: if (last) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state != ST_IDLE);
    done           = (state == ST_DONE);
    ctrl.load_key  = (state == ST_IDLE) && start && !keys_ready;
    ctrl.load_blk  = (state == ST_LOAD);
    ctrl.step      = (state == ST_KEY) || (state == ST_DATA);
    ctrl.key_sched = (state == ST_KEY);
    ram_we         = (state == ST_KEY);
    ridx           = (state == ST_LOAD) ? '0 : cnt + RK_AW'(1);
    ram_raddr      = decrypt_mode ? ~ridx : ridx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      keys_ready <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= ctrl.step ? cnt + RK_AW'(1) : '0;
      if (key_write) begin
        keys_ready <= 1'b0;
      end else if (state == ST_KEY && last) begin
        keys_ready <= 1'b1;
      end
    end
  end

endmodule

### rtl/sm4_block_cipher_unit.sv
// Top level of the SM4 block cipher unit: configuration registers, input item
// capture, sequencer, shared round unit and round key store. Uses sm4_pkg.
//
// Usage:
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 key_high,
//   1 key_low, 2 decrypt_mode, bit 0 only); index 3 is ignored. Write only
//   while busy is low. A key write marks the round keys stale.
//   Input: an item is taken at a clock edge with start high and busy low.
//   Output: done is high for one cycle with the result on result.
//   Sequence: a taken item passes the load state, then 32 rounds on the shared
//   round unit, then the done state; busy drops the next cycle, so a new item is
//   taken only after done. The first item after a key write first runs the key
//   expansion into the round key store, before the load state.
//   Round keys come from the store one per round through its registered read
//   port, with the address issued in the cycle before the round that uses it.
//   Reset: rst (synchronous) returns to idle, clears the key and mode to zero
//   and marks the keys stale. The receiver cannot stall; done is not held.
`timescale 1ns / 1ps
module sm4_block_cipher_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sm4_pkg::block_t   block,
  output logic              done,
  output sm4_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import sm4_pkg::*;

  logic [63:0]      key_high;
  logic [63:0]      key_low;
  logic             decrypt_mode;
  logic             key_write;
  logic [127:0]     blk;
  dp_ctrl_t         ctrl;
  logic [RK_AW-1:0] cnt;
  logic             ram_we;
  logic [RK_AW-1:0] ram_raddr;
  logic [31:0]      rk;
  logic [31:0]      new_word;

  assign key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH:     key_high     <= cfg_data;
        REG_KEY_LOW:      key_low      <= cfg_data;
        REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      blk <= block;
    end
  end

  sm4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .key_write    (key_write),
    .decrypt_mode (decrypt_mode),
    .busy         (busy),
    .done         (done),
    .ctrl         (ctrl),
    .cnt          (cnt),
    .ram_we       (ram_we),
    .ram_raddr    (ram_raddr)
  );

  sm4_key_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt),
    .wdata (new_word),
    .raddr (ram_raddr),
    .rdata (rk)
  );

  sm4_datapath u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .cnt      (cnt),
    .key      ({key_high, key_low}),
    .blk      (blk),
    .rk       (rk),
    .new_word (new_word),
    .result   (result)
  );

endmodule

### rtl/sm4_checker.sv
// Port-level checks for the SM4 block cipher unit and the bind that attaches
// them. Depends on sm4_block_cipher_unit.
`timescale 1ns / 1ps
module sm4_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("item taken but block not busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe not a single cycle ending the item");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 !done)
    else $error("result too early");

endmodule

bind sm4_block_cipher_unit sm4_checker u_chk (.*);
